@@ hw/rtl/amsd_pkg.sv @@
package amsd_pkg;

	// parse phases
	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_CHEAD  = 3'd1;
	localparam logic [2:0] PH_COMM   = 3'd2;
	localparam logic [2:0] PH_SSND   = 3'd3;
	localparam logic [2:0] PH_SKIP   = 3'd4;
	localparam logic [2:0] PH_DRAIN  = 3'd5;

	// verdict status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_HDR  = 3'd1;
	localparam logic [2:0] ST_BAD_COMM = 3'd2;
	localparam logic [2:0] ST_NOT_M8   = 3'd3;
	localparam logic [2:0] ST_BAD_SSND = 3'd4;
	localparam logic [2:0] ST_MISSING  = 3'd5;

	// chunk tags, big-endian ascii
	localparam logic [31:0] TAG_FORM = 32'h464F_524D;
	localparam logic [31:0] TAG_AIFF = 32'h4149_4646;
	localparam logic [31:0] TAG_COMM = 32'h434F_4D4D;
	localparam logic [31:0] TAG_SSND = 32'h5353_4E44;

	localparam logic [31:0] COMM_LEN   = 32'd18;
	localparam logic [7:0]  RATE_BIAS  = 8'd30;
	localparam logic [7:0]  SAMPLE_OFS = 8'h80;

	// one queue entry: the results caused by one byte
	typedef struct packed {
		logic        has_sample;
		logic [7:0]  sample;
		logic        has_verdict;
		logic [2:0]  status;
		logic [15:0] channels;
		logic [31:0] frames;
		logic [15:0] bits;
		logic [31:0] rate;
	} amsd_entry_t;

endpackage

@@ hw/rtl/amsd_queue.sv @@
module amsd_queue #(
	parameter int DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  amsd_pkg::amsd_entry_t push_data,
	output logic                  full,
	input  logic                  pop,
	output amsd_pkg::amsd_entry_t pop_data,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	amsd_pkg::amsd_entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

@@ hw/rtl/amsd_front.sv @@
module amsd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            file_byte,
	input  logic                  end_of_file,
	output logic                  push,
	output amsd_pkg::amsd_entry_t push_data
);

	// extended-float rate to integer: shift top mantissa word, round on last bit out
	function automatic logic [31:0] conv_rate(input logic [7:0] expo, input logic [31:0] mant);
		logic [7:0]  sh;
		logic [32:0] wide;
		logic [31:0] res;
		sh   = amsd_pkg::RATE_BIAS - expo;
		wide = {mant, 1'b0} >> sh;
		if (sh == 8'd0) begin
			res = mant;
		end else if (sh > 8'd32) begin
			res = '0;
		end else begin
			res = wide[32:1] + {31'd0, wide[0]};
		end
		return res;
	endfunction

	logic [2:0]  phase_q, phase_n;
	logic [31:0] pos_q, pos_n, pos_inc;
	logic [31:0] tag_q, tag_n;
	logic [31:0] len_q, len_n;
	logic [15:0] chan_q, chan_n;
	logic [31:0] frames_q, frames_n;
	logic [15:0] bits_q, bits_n;
	logic [7:0]  expo_q, expo_n;
	logic [31:0] mant_q, mant_n;
	logic [31:0] rate_q, rate_n;
	logic        seen_q, seen_n;
	logic        samp_v, verd_v, restart;
	logic [2:0]  stat;
	logic [32:0] ssnd_need;

	assign pos_inc   = pos_q + 32'd1;
	assign ssnd_need = {1'b0, frames_q} + 33'd8;

	// next-state and result classification for one byte
	always_comb begin
		phase_n  = phase_q;
		pos_n    = pos_q;
		tag_n    = tag_q;
		len_n    = len_q;
		chan_n   = chan_q;
		frames_n = frames_q;
		bits_n   = bits_q;
		expo_n   = expo_q;
		mant_n   = mant_q;
		rate_n   = rate_q;
		seen_n   = seen_q;
		samp_v   = 1'b0;
		verd_v   = 1'b0;
		restart  = 1'b0;
		stat     = amsd_pkg::ST_OK;
		case (phase_q)
			amsd_pkg::PH_HEADER: begin
				if (pos_q < 32'd4) begin
					tag_n = {tag_q[23:0], file_byte};
				end else begin
					len_n = {len_q[23:0], file_byte};
				end
				if (pos_q == 32'd11) begin
					if (tag_n != amsd_pkg::TAG_FORM || len_n != amsd_pkg::TAG_AIFF) begin
						verd_v = 1'b1;
						stat   = amsd_pkg::ST_BAD_HDR;
					end else begin
						phase_n = amsd_pkg::PH_CHEAD;
						pos_n   = '0;
						tag_n   = '0;
						len_n   = '0;
					end
				end else begin
					pos_n = pos_inc;
				end
			end
			amsd_pkg::PH_CHEAD: begin
				if (pos_q < 32'd4) begin
					tag_n = {tag_q[23:0], file_byte};
				end else begin
					len_n = {len_q[23:0], file_byte};
				end
				if (pos_q == 32'd7) begin
					pos_n = '0;
					if (tag_n == amsd_pkg::TAG_COMM) begin
						if (len_n != amsd_pkg::COMM_LEN) begin
							verd_v = 1'b1;
							stat   = amsd_pkg::ST_BAD_COMM;
						end else begin
							phase_n = amsd_pkg::PH_COMM;
						end
					end else if (tag_n == amsd_pkg::TAG_SSND) begin
						// only 8-bit mono gets past COMM, so the body is frames plus prefix
						if ({1'b0, len_n} != ssnd_need) begin
							verd_v = 1'b1;
							stat   = amsd_pkg::ST_BAD_SSND;
						end else begin
							phase_n = amsd_pkg::PH_SSND;
						end
					end else if (len_n != '0) begin
						phase_n = amsd_pkg::PH_SKIP;
					end
				end else begin
					pos_n = pos_inc;
				end
			end
			amsd_pkg::PH_COMM: begin
				if (pos_q < 32'd2) begin
					chan_n = {chan_q[7:0], file_byte};
				end else if (pos_q < 32'd6) begin
					frames_n = {frames_q[23:0], file_byte};
				end else if (pos_q < 32'd8) begin
					bits_n = {bits_q[7:0], file_byte};
				end else if (pos_q == 32'd9) begin
					expo_n = file_byte;
				end else if (pos_q >= 32'd10 && pos_q < 32'd14) begin
					mant_n = {mant_q[23:0], file_byte};
				end
				if (pos_q == 32'd17) begin
					rate_n = conv_rate(expo_q, mant_q);
					pos_n  = '0;
					if (bits_q != 16'd8 || chan_q != 16'd1) begin
						verd_v = 1'b1;
						stat   = amsd_pkg::ST_NOT_M8;
					end else begin
						phase_n = amsd_pkg::PH_CHEAD;
					end
				end else begin
					pos_n = pos_inc;
				end
			end
			amsd_pkg::PH_SSND: begin
				samp_v = (pos_q >= 32'd8);
				if (pos_q == len_q - 32'd1) begin
					seen_n  = 1'b1;
					phase_n = amsd_pkg::PH_CHEAD;
					pos_n   = '0;
				end else begin
					pos_n = pos_inc;
				end
			end
			amsd_pkg::PH_SKIP: begin
				if (pos_q == len_q - 32'd1) begin
					phase_n = amsd_pkg::PH_CHEAD;
					pos_n   = '0;
				end else begin
					pos_n = pos_inc;
				end
			end
			default: begin
				// draining after an error: wait for the end of the file
				restart = end_of_file;
			end
		endcase

		// end of file without an early error
		if (phase_q <= amsd_pkg::PH_SKIP && !verd_v && end_of_file) begin
			verd_v = 1'b1;
			case (phase_n)
				amsd_pkg::PH_HEADER: stat = amsd_pkg::ST_BAD_HDR;
				amsd_pkg::PH_COMM:   stat = amsd_pkg::ST_BAD_COMM;
				amsd_pkg::PH_SSND:   stat = amsd_pkg::ST_BAD_SSND;
				default: begin
					if (chan_n == '0 || frames_n == '0 || bits_n == '0 || rate_n == '0 ||
						!seen_n) begin
						stat = amsd_pkg::ST_MISSING;
					end else begin
						stat = amsd_pkg::ST_OK;
					end
				end
			endcase
		end

		if (verd_v) begin
			if (end_of_file) begin
				restart = 1'b1;
			end else begin
				phase_n = amsd_pkg::PH_DRAIN;
				pos_n   = '0;
			end
		end
	end

	// queue entry reports stored values after this byte
	assign push                  = accept && (samp_v || verd_v);
	assign push_data.has_sample  = samp_v;
	assign push_data.sample      = file_byte ^ amsd_pkg::SAMPLE_OFS;
	assign push_data.has_verdict = verd_v;
	assign push_data.status      = stat;
	assign push_data.channels    = chan_n;
	assign push_data.frames      = frames_n;
	assign push_data.bits        = bits_n;
	assign push_data.rate        = rate_n;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= amsd_pkg::PH_HEADER;
			pos_q    <= '0;
			tag_q    <= '0;
			len_q    <= '0;
			chan_q   <= '0;
			frames_q <= '0;
			bits_q   <= '0;
			expo_q   <= '0;
			mant_q   <= '0;
			rate_q   <= '0;
			seen_q   <= 1'b0;
		end else if (accept) begin
			if (restart) begin
				phase_q  <= amsd_pkg::PH_HEADER;
				pos_q    <= '0;
				tag_q    <= '0;
				len_q    <= '0;
				chan_q   <= '0;
				frames_q <= '0;
				bits_q   <= '0;
				expo_q   <= '0;
				mant_q   <= '0;
				rate_q   <= '0;
				seen_q   <= 1'b0;
			end else begin
				phase_q  <= phase_n;
				pos_q    <= pos_n;
				tag_q    <= tag_n;
				len_q    <= len_n;
				chan_q   <= chan_n;
				frames_q <= frames_n;
				bits_q   <= bits_n;
				expo_q   <= expo_n;
				mant_q   <= mant_n;
				rate_q   <= rate_n;
				seen_q   <= seen_n;
			end
		end
	end

endmodule

@@ hw/rtl/amsd_back.sv @@
module amsd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  amsd_pkg::amsd_entry_t q_data,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  item_kind,
	output logic signed [7:0]     pcm_sample,
	output logic [2:0]            status,
	output logic [15:0]           channel_total,
	output logic [31:0]           frame_total,
	output logic [15:0]           bits_per_sample,
	output logic [31:0]           rate_hz,
	output logic                  run_end
);

	amsd_pkg::amsd_entry_t hold_q;
	logic hold_v_q;
	logic both, fire, last, load;

	assign both  = hold_q.has_sample && hold_q.has_verdict;
	assign fire  = hold_v_q && out_ready;
	assign last  = fire && !both;
	assign load  = (!hold_v_q || last) && !q_empty;
	assign q_pop = load;

	// result mux: sample goes out before the verdict of the same byte
	assign out_valid       = hold_v_q;
	assign item_kind       = !hold_q.has_sample;
	assign run_end         = !both;
	assign pcm_sample      = hold_q.has_sample ? $signed(hold_q.sample) : 8'sd0;
	assign status          = hold_q.has_sample ? amsd_pkg::ST_OK : hold_q.status;
	assign channel_total   = hold_q.has_sample ? 16'd0 : hold_q.channels;
	assign frame_total     = hold_q.has_sample ? 32'd0 : hold_q.frames;
	assign bits_per_sample = hold_q.has_sample ? 16'd0 : hold_q.bits;
	assign rate_hz         = hold_q.has_sample ? 32'd0 : hold_q.rate;

	// holding register payload
	always_ff @(posedge clk) begin
		if (load) begin
			hold_q <= q_data;
		end else if (fire) begin
			hold_q.has_sample <= 1'b0;
		end
	end

	// holding register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
		end else if (load) begin
			hold_v_q <= 1'b1;
		end else if (last) begin
			hold_v_q <= 1'b0;
		end
	end

endmodule

@@ hw/rtl/aiff_mono8_stream_decoder.sv @@
// Byte-serial parser for 8-bit mono AIFF files. One file byte is taken per cycle whenever
// the result queue between parser and output stage has room (QUEUE_DEPTH entries); a byte
// inside the SSND sample data yields one converted sample, and a byte that ends the file or
// hits an error yields a verdict, so one byte may give two results, sent one after the other.
// Results pass through the result queue and a holding register, one per cycle while out_ready
// is high; a steady rate of one byte per cycle holds while out_ready is high and bytes give at
// most one result each. After an error, bytes are dropped up to the next end-of-file byte,
// and every end-of-file byte starts the next file from a clean state.
module aiff_mono8_stream_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        file_byte,
	input  logic              end_of_file,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              item_kind,
	output logic signed [7:0] pcm_sample,
	output logic [2:0]        status,
	output logic [15:0]       channel_total,
	output logic [31:0]       frame_total,
	output logic [15:0]       bits_per_sample,
	output logic [31:0]       rate_hz,
	output logic              run_end
);

	amsd_pkg::amsd_entry_t push_data, pop_data;
	logic push, pop, full, empty, accept;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	// parser front
	amsd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.file_byte   (file_byte),
		.end_of_file (end_of_file),
		.push        (push),
		.push_data   (push_data)
	);

	// result queue
	amsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// output stage
	amsd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (empty),
		.q_data          (pop_data),
		.q_pop           (pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.item_kind       (item_kind),
		.pcm_sample      (pcm_sample),
		.status          (status),
		.channel_total   (channel_total),
		.frame_total     (frame_total),
		.bits_per_sample (bits_per_sample),
		.rate_hz         (rate_hz),
		.run_end         (run_end)
	);

endmodule

@@ verif/aiff_mono8_stream_decoder_tb.sv @@
module aiff_mono8_stream_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic KIND_SAMPLE  = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// chunk kinds used by the file generator
	localparam int CK_COMM  = 0;
	localparam int CK_SSND  = 1;
	localparam int CK_OTHER = 2;

	// no idling once this few bytes are left to send
	localparam int CALM_TAIL   = 120;
	localparam int FILE_TARGET = 1150;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} file_beat_t;

	typedef struct {
		logic        kind;
		logic [7:0]  pcm;
		logic [2:0]  st;
		logic [15:0] chans;
		logic [31:0] frames;
		logic [15:0] bits;
		logic [31:0] rate;
		logic        fin;
	} decoded_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] file_byte = 8'd0;
	logic end_of_file = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic item_kind;
	logic signed [7:0] pcm_sample;
	logic [2:0] status;
	logic [15:0] channel_total;
	logic [31:0] frame_total;
	logic [15:0] bits_per_sample;
	logic [31:0] rate_hz;
	logic run_end;

	file_beat_t file_bytes_q[$];
	decoded_t decoded_q[$];
	logic [7:0] file_image[$];
	int fail_count = 0;

	int gap_left = 0;
	int stall_left = 0;
	logic in_busy = 1'b1;
	logic out_busy = 1'b1;

	// decoder state mirror
	logic [2:0]  ph;
	logic [32:0] bpos;
	logic [31:0] cur_tag;
	logic [31:0] cur_len;
	logic [15:0] comm_chans;
	logic [31:0] comm_frames;
	logic [15:0] comm_bits;
	logic [7:0]  rate_exp;
	logic [31:0] rate_mant;
	logic [31:0] comm_rate;
	logic        got_ssnd;

	aiff_mono8_stream_decoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.file_byte(file_byte),
		.end_of_file(end_of_file),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.item_kind(item_kind),
		.pcm_sample(pcm_sample),
		.status(status),
		.channel_total(channel_total),
		.frame_total(frame_total),
		.bits_per_sample(bits_per_sample),
		.rate_hz(rate_hz),
		.run_end(run_end)
	);

	always #5 clk = ~clk;

	// 80-bit extended rate to integer: shift the top mantissa word, round on last bit out
	function automatic logic [31:0] rate_to_hz(input logic [7:0] e, input logic [31:0] m);
		logic [7:0]  sh;
		logic [63:0] wide;
		sh = amsd_pkg::RATE_BIAS - e;
		wide = {32'd0, m};
		if (sh == 8'd0)
			return m;
		if (sh > 8'd32)
			return 32'd0;
		return 32'((wide >> sh) + ((wide >> (sh - 8'd1)) & 64'd1));
	endfunction

	task automatic clear_state();
		ph = amsd_pkg::PH_HEADER;
		bpos = '0;
		cur_tag = '0;
		cur_len = '0;
		comm_chans = '0;
		comm_frames = '0;
		comm_bits = '0;
		rate_exp = '0;
		rate_mant = '0;
		comm_rate = '0;
		got_ssnd = 1'b0;
	endtask

	// advance the mirror by one file byte and queue the results it causes
	task automatic decode_byte(input logic [7:0] b, input logic eof);
		decoded_t    smp;
		decoded_t    vrd;
		logic        has_smp;
		logic        has_vrd;
		logic [2:0]  code;
		logic [63:0] need;
		has_smp = 1'b0;
		has_vrd = 1'b0;
		code = amsd_pkg::ST_OK;
		smp = '{default: '0};
		if (ph == amsd_pkg::PH_DRAIN) begin
			if (eof)
				clear_state();
		end else begin
			case (ph)
				amsd_pkg::PH_HEADER: begin
					if (bpos < 4)
						cur_tag = {cur_tag[23:0], b};
					else
						cur_len = {cur_len[23:0], b};
					if (bpos == 11) begin
						if (cur_tag != amsd_pkg::TAG_FORM || cur_len != amsd_pkg::TAG_AIFF) begin
							has_vrd = 1'b1;
							code = amsd_pkg::ST_BAD_HDR;
						end else begin
							ph = amsd_pkg::PH_CHEAD;
							bpos = '0;
							cur_tag = '0;
							cur_len = '0;
						end
					end else begin
						bpos++;
					end
				end
				amsd_pkg::PH_CHEAD: begin
					if (bpos < 4)
						cur_tag = {cur_tag[23:0], b};
					else
						cur_len = {cur_len[23:0], b};
					if (bpos == 7) begin
						bpos = '0;
						if (cur_tag == amsd_pkg::TAG_COMM) begin
							if (cur_len != amsd_pkg::COMM_LEN) begin
								has_vrd = 1'b1;
								code = amsd_pkg::ST_BAD_COMM;
							end else begin
								ph = amsd_pkg::PH_COMM;
							end
						end else if (cur_tag == amsd_pkg::TAG_SSND) begin
							need = 64'(comm_bits / 16'd8) * 64'(comm_frames) * 64'(comm_chans)
								+ 64'd8;
							if (64'(cur_len) != need) begin
								has_vrd = 1'b1;
								code = amsd_pkg::ST_BAD_SSND;
							end else begin
								ph = amsd_pkg::PH_SSND;
							end
						end else if (cur_len != 32'd0) begin
							ph = amsd_pkg::PH_SKIP;
						end
					end else begin
						bpos++;
					end
				end
				amsd_pkg::PH_COMM: begin
					if (bpos < 2)
						comm_chans = {comm_chans[7:0], b};
					else if (bpos < 6)
						comm_frames = {comm_frames[23:0], b};
					else if (bpos < 8)
						comm_bits = {comm_bits[7:0], b};
					else if (bpos == 9)
						rate_exp = b;
					else if (bpos >= 10 && bpos < 14)
						rate_mant = {rate_mant[23:0], b};
					if (bpos == 17) begin
						comm_rate = rate_to_hz(rate_exp, rate_mant);
						bpos = '0;
						if (comm_bits != 16'd8 || comm_chans != 16'd1) begin
							has_vrd = 1'b1;
							code = amsd_pkg::ST_NOT_M8;
						end else begin
							ph = amsd_pkg::PH_CHEAD;
						end
					end else begin
						bpos++;
					end
				end
				amsd_pkg::PH_SSND: begin
					if (bpos >= 8) begin
						has_smp = 1'b1;
						smp.pcm = b ^ amsd_pkg::SAMPLE_OFS;
					end
					if (bpos + 33'd1 >= {1'b0, cur_len}) begin
						got_ssnd = 1'b1;
						ph = amsd_pkg::PH_CHEAD;
						bpos = '0;
					end else begin
						bpos++;
					end
				end
				amsd_pkg::PH_SKIP: begin
					if (bpos + 33'd1 >= {1'b0, cur_len}) begin
						ph = amsd_pkg::PH_CHEAD;
						bpos = '0;
					end else begin
						bpos++;
					end
				end
				default: ;
			endcase

			// file ends here: status depends on where the parse stands
			if (!has_vrd && eof) begin
				has_vrd = 1'b1;
				case (ph)
					amsd_pkg::PH_HEADER: code = amsd_pkg::ST_BAD_HDR;
					amsd_pkg::PH_COMM:   code = amsd_pkg::ST_BAD_COMM;
					amsd_pkg::PH_SSND:   code = amsd_pkg::ST_BAD_SSND;
					default:   code = (comm_chans == 0 || comm_frames == 0 || comm_bits == 0 ||
						comm_rate == 0 || !got_ssnd) ? amsd_pkg::ST_MISSING : amsd_pkg::ST_OK;
				endcase
			end

			if (has_smp) begin
				smp.kind = KIND_SAMPLE;
				smp.fin = !has_vrd;
				decoded_q.push_back(smp);
			end
			if (has_vrd) begin
				vrd.kind = KIND_VERDICT;
				vrd.pcm = '0;
				vrd.st = code;
				vrd.chans = comm_chans;
				vrd.frames = comm_frames;
				vrd.bits = comm_bits;
				vrd.rate = comm_rate;
				vrd.fin = 1'b1;
				decoded_q.push_back(vrd);
				if (eof) begin
					clear_state();
				end else begin
					ph = amsd_pkg::PH_DRAIN;
					bpos = '0;
				end
			end
		end
	endtask

	task automatic check_field(input string fname, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result();
		decoded_t want;
		if (decoded_q.size() == 0) begin
			$display("%0t: result with none expected, actual kind %0d status %0d sample %0h",
				$time, item_kind, status, pcm_sample);
			fail_count++;
		end else begin
			want = decoded_q.pop_front();
			check_field("item_kind", {31'd0, want.kind}, {31'd0, item_kind});
			check_field("pcm_sample", {24'd0, want.pcm}, {24'd0, pcm_sample});
			check_field("status", {29'd0, want.st}, {29'd0, status});
			check_field("channel_total", {16'd0, want.chans}, {16'd0, channel_total});
			check_field("frame_total", want.frames, frame_total);
			check_field("bits_per_sample", {16'd0, want.bits}, {16'd0, bits_per_sample});
			check_field("rate_hz", want.rate, rate_hz);
			check_field("run_end", {31'd0, want.fin}, {31'd0, run_end});
		end
	endtask

	// file image building
	task automatic put_be(input logic [31:0] v, input int n);
		for (int i = n - 1; i >= 0; i--)
			file_image.push_back(v[8*i +: 8]);
	endtask

	task automatic put_noise(input int n);
		for (int i = 0; i < n; i++)
			file_image.push_back(8'($urandom));
	endtask

	// queue the image up to the byte that carries end of file
	task automatic ship_image(input int cut);
		file_beat_t fb;
		for (int i = 0; i <= cut; i++) begin
			fb.data = file_image[i];
			fb.last = (i == cut);
			file_bytes_q.push_back(fb);
		end
		file_image.delete();
	endtask

	// mostly well-formed files with random content, some broken or cut short
	task automatic build_random_file();
		logic [15:0] g_chans;
		logic [15:0] g_bits;
		logic [31:0] g_frames;
		logic [31:0] clen;
		logic [7:0]  rexp;
		logic [63:0] need;
		int          nchunks;
		int          kind;
		int          idx;
		int          cut;
		g_chans = '0;
		g_bits = '0;
		g_frames = '0;
		if ($urandom_range(0, 14) == 0) begin
			put_noise($urandom_range(1, 20));
			ship_image(file_image.size() - 1);
			return;
		end
		put_be(amsd_pkg::TAG_FORM, 4);
		put_be($urandom, 4);
		put_be(amsd_pkg::TAG_AIFF, 4);
		// occasionally damage one tag byte of the header
		if ($urandom_range(0, 11) == 0) begin
			idx = $urandom_range(0, 7);
			if (idx >= 4)
				idx += 4;
			file_image[idx] ^= 8'(1 << $urandom_range(0, 7));
		end
		nchunks = $urandom_range(1, 4);
		for (int k = 0; k < nchunks; k++) begin
			if (k == 0 && $urandom_range(0, 4) != 0)
				kind = CK_COMM;
			else if (k == 1 && $urandom_range(0, 4) != 0)
				kind = CK_SSND;
			else
				kind = $urandom_range(0, 2);
			case (kind)
				CK_COMM: begin
					clen = amsd_pkg::COMM_LEN;
					if ($urandom_range(0, 11) == 0) begin
						case ($urandom_range(0, 3))
							0: clen = 32'd17;
							1: clen = 32'd19;
							2: clen = 32'd0;
							default: clen = $urandom;
						endcase
					end
					g_chans = 16'd1;
					if ($urandom_range(0, 7) == 0) begin
						case ($urandom_range(0, 3))
							0: g_chans = 16'd0;
							1: g_chans = 16'd2;
							2: g_chans = 16'hFFFF;
							default: g_chans = 16'($urandom);
						endcase
					end
					g_frames = $urandom_range(1, 24);
					if ($urandom_range(0, 9) == 0) begin
						case ($urandom_range(0, 3))
							0: g_frames = 32'd0;
							1: g_frames = 32'hFFFF_FFFF;
							2: g_frames = 32'hFFFF_FFF8;
							default: g_frames = $urandom;
						endcase
					end
					g_bits = 16'd8;
					if ($urandom_range(0, 7) == 0) begin
						case ($urandom_range(0, 4))
							0: g_bits = 16'd0;
							1: g_bits = 16'd16;
							2: g_bits = 16'd7;
							3: g_bits = 16'hFFFF;
							default: g_bits = 16'($urandom);
						endcase
					end
					// rate exponent: exact, typical, small shifts, wrap to huge shift
					case ($urandom_range(0, 5))
						0: rexp = 8'd14;
						1: rexp = amsd_pkg::RATE_BIAS;
						2: rexp = 8'($urandom_range(31, 255));
						3: rexp = 8'($urandom_range(0, 29));
						4: rexp = 8'd254;
						default: rexp = 8'($urandom_range(12, 20));
					endcase
					put_be(amsd_pkg::TAG_COMM, 4);
					put_be(clen, 4);
					put_be(32'(g_chans), 2);
					put_be(g_frames, 4);
					put_be(32'(g_bits), 2);
					put_be($urandom, 1);
					put_be(32'(rexp), 1);
					put_be(($urandom_range(0, 9) == 0) ? 32'd0 : $urandom, 4);
					put_be($urandom, 4);
				end
				CK_SSND: begin
					need = 64'(g_bits / 16'd8) * 64'(g_frames) * 64'(g_chans) + 64'd8;
					clen = need[31:0];
					if (need[63:32] == 0 && need > 64'd72) begin
						// keep sample runs short: force a length error instead
						clen = need[31:0] ^ 32'd1;
					end else if ($urandom_range(0, 9) == 0) begin
						case ($urandom_range(0, 2))
							0: clen = need[31:0] + 32'd1;
							1: clen = need[31:0] - 32'd1;
							default: clen = $urandom_range(0, 7);
						endcase
					end
					put_be(amsd_pkg::TAG_SSND, 4);
					put_be(clen, 4);
					put_noise((64'(clen) == need) ? int'(clen) : $urandom_range(0, 4));
				end
				default: begin
					put_be($urandom, 4);
					if ($urandom_range(0, 9) == 0) begin
						// long chunk that the file end cuts into
						put_be($urandom, 4);
						put_noise(3);
					end else begin
						clen = $urandom_range(0, 6);
						put_be(clen, 4);
						put_noise(int'(clen));
					end
				end
			endcase
		end
		cut = file_image.size() - 1;
		if ($urandom_range(0, 5) == 0)
			cut = $urandom_range(0, cut);
		ship_image(cut);
	endtask

	// input driver: one file byte per beat, random gaps between beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			file_byte <= 8'd0;
			end_of_file <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready)
				decode_byte(file_byte, end_of_file);
			if (($urandom & 63) == 0)
				in_busy <= ~in_busy;
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (file_bytes_q.size() > 0) begin
					if (in_busy && file_bytes_q.size() >= CALM_TAIL &&
						$urandom_range(0, 7) == 0) begin
						gap_left <= $urandom_range(0, 18);
						in_valid <= 1'b0;
					end else begin
						file_byte <= file_bytes_q[0].data;
						end_of_file <= file_bytes_q[0].last;
						void'(file_bytes_q.pop_front());
						in_valid <= 1'b1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random stall bursts on out_ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (($urandom & 63) == 0)
				out_busy <= ~out_busy;
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (out_busy && file_bytes_q.size() >= CALM_TAIL &&
				$urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 18);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// stimulus and end of run
	initial begin
		clear_state();

		// short directed files: lone end byte, damaged format tag, header cut short
		file_image.push_back(8'hFF);
		ship_image(0);
		put_be(amsd_pkg::TAG_FORM, 4);
		put_be(32'd0, 4);
		put_be(amsd_pkg::TAG_AIFF ^ 32'd1, 4);
		put_noise(2);
		ship_image(file_image.size() - 1);
		put_be(amsd_pkg::TAG_FORM, 4);
		put_be(32'hFFFF_FFFF, 4);
		ship_image(5);

		while (file_bytes_q.size() < FILE_TARGET)
			build_random_file();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (file_bytes_q.size() > 0 || in_valid)
			@(posedge clk);
		while (decoded_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("aiff_mono8_stream_decoder test passed");
		else
			$display("aiff_mono8_stream_decoder test failed");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("aiff_mono8_stream_decoder test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/amsd_pkg.sv
hw/rtl/amsd_queue.sv
hw/rtl/amsd_front.sv
hw/rtl/amsd_back.sv
hw/rtl/aiff_mono8_stream_decoder.sv
verif/aiff_mono8_stream_decoder_tb.sv
